// File: src/mws_pkg.sv
// ----------------------------------------------------------------------------
// mws_pkg: shared types and constants for the minimum window search
// Command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mws_pkg;

   localparam int COUNT_MAX = 2047;
   localparam int OWED_MAX  = 2047;
   localparam int OWED_W    = 11;
   localparam int START_W   = 10;
   localparam int LENGTH_W  = 11;

   typedef struct packed {
      logic latch_req;   // capture the accepted item
      logic cnt_rd;      // read a count entry
      logic cnt_src_txt; // count address from text data, else from the item byte
      logic txt_wr;      // store the text byte
      logic txt_rd;      // read the text byte under the left edge
      logic pat_update;  // apply a pattern byte
      logic txt_update;  // apply a text byte
      logic walk_step;   // move the left edge over a surplus byte
      logic rec;         // record the window and give back the leftmost byte
      logic rsp_load;    // load the result registers
      logic clear;       // clear the job state
   } cmd_type;

   typedef struct packed {
      logic op_text;
      logic last;
      logic text_full;
      logic hit;
      logic walk_stop;
      logic window_full;
   } status_type;

endpackage

`default_nettype wire

// File: src/mws_ram.sv
// ----------------------------------------------------------------------------
// mws_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: src/mws_ctrl.sv
// ----------------------------------------------------------------------------
// mws_ctrl: sequencer for the minimum window search
// Steps each item through count lookup, update and the left edge walk.
// ----------------------------------------------------------------------------
`default_nettype none

module mws_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_op,
   input  wire logic                req_last,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire mws_pkg::status_type status,
   output mws_pkg::cmd_type         cmd
);
   import mws_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CRD, S_PAT, S_TXT, S_CHK, S_WRD, S_WCR, S_WEV, S_REC, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, slot_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.latch_req = 1'b1;
               if (req_op && status.text_full) begin
                  state_in = req_last ? S_DONE : S_IDLE;
               end else begin
                  state_in = S_CRD;
               end
            end
         end
         S_CRD: begin
            cmd.cnt_rd = 1'b1;
            cmd.txt_wr = status.op_text;
            state_in   = status.op_text ? S_TXT : S_PAT;
         end
         S_PAT: begin
            cmd.pat_update = 1'b1;
            state_in       = S_IDLE;
         end
         S_TXT: begin
            cmd.txt_update = 1'b1;
            if (status.hit) begin
               state_in = S_CHK;
            end else begin
               state_in = status.last ? S_DONE : S_IDLE;
            end
         end
         S_CHK: begin
            if (status.window_full) begin
               state_in = S_WRD;
            end else begin
               state_in = status.last ? S_DONE : S_IDLE;
            end
         end
         S_WRD: begin
            cmd.txt_rd = 1'b1;
            state_in   = S_WCR;
         end
         S_WCR: begin
            cmd.cnt_rd      = 1'b1;
            cmd.cnt_src_txt = 1'b1;
            state_in        = S_WEV;
         end
         S_WEV: begin
            if (status.walk_stop) begin
               state_in = S_REC;
            end else begin
               cmd.walk_step = 1'b1;
               state_in      = S_WRD;
            end
         end
         S_REC: begin
            cmd.rec  = 1'b1;
            state_in = S_CHK;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A waiting result is never overwritten.
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

   // The walk only starts from the completeness check.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRD) |-> ($past(state_ff) == S_CHK || $past(state_ff) == S_WEV))
      else $error("walk entered from wrong state");

   // A load always produces a result transfer offer in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("result not offered after load");

endmodule

`default_nettype wire

// File: src/mws_dpath.sv
// ----------------------------------------------------------------------------
// mws_dpath: datapath for the minimum window search
// Count table, text store, window edges, owed counter and best window.
// ----------------------------------------------------------------------------
`default_nettype none

module mws_dpath #(
   parameter int MAX_TEXT = 1024,
   parameter int ALPHABET = 256
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_op,
   input  wire logic [7:0]               req_ch,
   input  wire logic                     req_last,
   input  wire mws_pkg::cmd_type         cmd,
   output mws_pkg::status_type           status,
   output logic                          rsp_found,
   output logic [mws_pkg::START_W-1:0]   rsp_start_res,
   output logic [mws_pkg::LENGTH_W-1:0]  rsp_length
);
   import mws_pkg::*;

   localparam int PW = $clog2(MAX_TEXT + 1);
   localparam int TW = $clog2(MAX_TEXT);
   localparam int AW = $clog2(ALPHABET);
   localparam int CW = (PW + 1 > 12) ? PW + 1 : 12;

   logic              op_ff, last_ff;
   logic [7:0]        ch_ff;
   logic [TW-1:0]     r_ff;
   logic [PW-1:0]     right_ff, right_in, left_ff, left_in;
   logic [OWED_W-1:0] owed_ff, owed_in;
   logic [PW-1:0]     best_len_ff, best_len_in;
   logic [TW-1:0]     best_start_ff, best_start_in;
   logic [ALPHABET-1:0] vld_ff;
   logic              rd_vld_ff, rd_alpha_ff;
   logic [AW-1:0]     cnt_addr_ff;
   logic              found_ff;
   logic [START_W-1:0]  start_ff;
   logic [LENGTH_W-1:0] len_ff;

   logic [7:0]        txt_rdata, cnt_src;
   logic [CW:0]       cnt_rdata, cnt_wdata;
   logic              cnt_we, src_alpha;
   logic              hit;
   logic signed [CW-1:0] cnt, cnt_inc, cnt_dec;
   logic              cnt_pos, cnt_nonneg, pat_ok;
   logic [PW-1:0]     r_ext, win_len;

   assign cnt_src   = cmd.cnt_src_txt ? txt_rdata : ch_ff;
   assign src_alpha = ({1'b0, cnt_src} < 9'(ALPHABET));

   // Entries never written since the last clear read as zero.
   assign hit        = rd_vld_ff && rd_alpha_ff && cnt_rdata[CW];
   assign cnt        = (rd_vld_ff && rd_alpha_ff) ? signed'(cnt_rdata[CW-1:0]) : '0;
   assign cnt_inc    = cnt + CW'(1);
   assign cnt_dec    = cnt - CW'(1);
   assign cnt_nonneg = !cnt[CW-1];
   assign cnt_pos    = cnt_nonneg && (cnt != '0);
   assign pat_ok     = rd_alpha_ff && (cnt < signed'(CW'(COUNT_MAX)))
                       && !(cnt_nonneg && (owed_ff >= OWED_W'(OWED_MAX)));

   assign r_ext   = PW'(r_ff);
   assign win_len = r_ext - left_ff + PW'(1);

   always_comb begin
      cnt_we    = 1'b0;
      cnt_wdata = {1'b1, cnt_inc};
      owed_in   = owed_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      if (cmd.pat_update && pat_ok) begin
         cnt_we = 1'b1;
         if (!cnt_inc[CW-1] && cnt_inc != '0) begin
            owed_in = owed_ff + OWED_W'(1);
         end
      end
      if (cmd.txt_update) begin
         right_in = right_ff + PW'(1);
         if (hit) begin
            cnt_we    = 1'b1;
            cnt_wdata = {1'b1, cnt_dec};
            if (cnt_pos) begin
               owed_in = owed_ff - OWED_W'(1);
            end
         end
      end
      if (cmd.walk_step) begin
         cnt_we  = hit;
         left_in = left_ff + PW'(1);
      end
      if (cmd.rec) begin
         if (best_len_ff == '0 || win_len < best_len_ff) begin
            best_len_in   = win_len;
            best_start_in = left_ff[TW-1:0];
         end
         cnt_we  = hit;
         left_in = left_ff + PW'(1);
         if (hit && !cnt_inc[CW-1] && cnt_inc != '0) begin
            owed_in = owed_ff + OWED_W'(1);
         end
      end
      if (cmd.clear) begin
         owed_in       = '0;
         left_in       = '0;
         right_in      = '0;
         best_len_in   = '0;
         best_start_in = '0;
      end
   end

   mws_ram #(.WIDTH(CW + 1), .DEPTH(ALPHABET)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_addr_ff),
      .wr_data (cnt_wdata),
      .rd_en   (cmd.cnt_rd),
      .rd_addr (cnt_src[AW-1:0]),
      .rd_data (cnt_rdata)
   );

   mws_ram #(.WIDTH(8), .DEPTH(MAX_TEXT)) u_text_ram (
      .clock   (clock),
      .wr_en   (cmd.txt_wr),
      .wr_addr (r_ff),
      .wr_data (ch_ff),
      .rd_en   (cmd.txt_rd),
      .rd_addr (left_ff[TW-1:0]),
      .rd_data (txt_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         owed_ff       <= '0;
         left_ff       <= '0;
         right_ff      <= '0;
         best_len_ff   <= '0;
         best_start_ff <= '0;
      end else begin
         if (cmd.clear) begin
            vld_ff <= '0;
         end else if (cnt_we) begin
            vld_ff[cnt_addr_ff] <= 1'b1;
         end
         owed_ff       <= owed_in;
         left_ff       <= left_in;
         right_ff      <= right_in;
         best_len_ff   <= best_len_in;
         best_start_ff <= best_start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff   <= req_op;
         ch_ff   <= req_ch;
         last_ff <= req_last;
         r_ff    <= right_ff[TW-1:0];
      end
      if (cmd.cnt_rd) begin
         cnt_addr_ff <= cnt_src[AW-1:0];
         rd_alpha_ff <= src_alpha;
         rd_vld_ff   <= src_alpha && vld_ff[cnt_src[AW-1:0]];
      end
      if (cmd.rsp_load) begin
         found_ff <= (best_len_ff != '0);
         start_ff <= START_W'(best_start_ff);
         len_ff   <= LENGTH_W'(best_len_ff);
      end
   end

   assign rsp_found     = found_ff;
   assign rsp_start_res = start_ff;
   assign rsp_length    = len_ff;

   assign status.op_text     = op_ff;
   assign status.last        = last_ff;
   assign status.text_full   = (right_ff >= PW'(MAX_TEXT));
   assign status.hit         = hit;
   assign status.walk_stop   = !(left_ff < r_ext) || (hit && cnt_nonneg);
   assign status.window_full = (owed_ff == '0) && (left_ff <= r_ext);

   // The left edge never passes the right edge.
   assert property (@(posedge clock) disable iff (reset) left_ff <= right_ff)
      else $error("left edge beyond right edge");

   // A clear empties the whole job state.
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (owed_ff == '0 && right_ff == '0 && vld_ff == '0))
      else $error("job state not cleared");

   // A recorded window never grows.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.rec && $past(best_len_ff) != '0 && best_len_ff != '0)
      |=> best_len_ff <= $past(best_len_ff))
      else $error("best window grew");

endmodule

`default_nettype wire

// File: src/min_window_substring.sv
// A pattern byte has its count read and updated; a text byte is also stored, and one
// that occurs in the pattern goes on to the window check. A left edge step reads the
// text byte, then its count; steps are amortised to at most one per stored text byte
// in a job. The last text byte waits in a done state while an earlier result is unsent.
// Synchronous reset clears the count table valid bits, pointers and handshake state.
`default_nettype none

module min_window_substring #(
   parameter int MAX_TEXT = 1024,
   parameter int ALPHABET = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_op,
   input  wire logic [7:0]                    req_ch,
   input  wire logic                          req_last,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_found,
   output logic [mws_pkg::START_W-1:0]        rsp_start_res,
   output logic [mws_pkg::LENGTH_W-1:0]       rsp_length
);
   import mws_pkg::*;

   cmd_type    cmd;
   status_type status;

   mws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mws_dpath #(.MAX_TEXT(MAX_TEXT), .ALPHABET(ALPHABET)) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_op        (req_op),
      .req_ch        (req_ch),
      .req_last      (req_last),
      .cmd           (cmd),
      .status        (status),
      .rsp_found     (rsp_found),
      .rsp_start_res (rsp_start_res),
      .rsp_length    (rsp_length)
   );

endmodule

`default_nettype wire

// File: tb/tb_min_window_substring.sv
// ----------------------------------------------------------------------------
// tb_min_window_substring: checks the minimum covering window search
// Drives pattern and text jobs through the valid/stall request channel,
// predicts each job result with a behavioural model and compares every
// transfer on the result channel, under random gaps and receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_min_window_substring;

   localparam int MAX_TEXT = 1024;
   localparam int ALPHABET = 256;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam bit OP_PATTERN = 1'b0;
   localparam bit OP_TEXT    = 1'b1;

   typedef struct packed {
      logic                         found;
      logic [mws_pkg::START_W-1:0]  start_res;
      logic [mws_pkg::LENGTH_W-1:0] length;
   } window_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = 1'b0;
   logic [7:0] req_ch = 8'd0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_found;
   logic [mws_pkg::START_W-1:0] rsp_start_res;
   logic [mws_pkg::LENGTH_W-1:0] rsp_length;

   min_window_substring dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_ch(req_ch), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_found(rsp_found),
      .rsp_start_res(rsp_start_res), .rsp_length(rsp_length)
   );

   always #10 clock = ~clock;

   // Predictor state for the current job.
   int         owed_per_byte[256];
   bit         needed[256];
   logic [7:0] text_mem[MAX_TEXT];
   int         left_edge, right_edge, owed_total, best_length, best_index;
   window_type expected_windows[$];

   int  error_count = 0;
   int  windows_checked = 0;
   int  items_sent = 0;
   int  idle_cycles = 0;
   bit  hold_results = 1'b0;
   bit  rsp_gaps_on = 1'b1;
   bit  req_gaps_on = 1'b1;

   task automatic clear_window_job();
      foreach (owed_per_byte[i]) begin
         owed_per_byte[i] = 0;
         needed[i] = 1'b0;
      end
      left_edge = 0;
      right_edge = 0;
      owed_total = 0;
      best_length = 0;
      best_index = 0;
   endtask

   task automatic add_pattern_byte(int ch);
      int c;
      c = owed_per_byte[ch];
      if (ch >= ALPHABET || c >= mws_pkg::COUNT_MAX) return;
      if (c >= 0 && owed_total >= mws_pkg::OWED_MAX) return;
      owed_per_byte[ch] = c + 1;
      needed[ch] = 1'b1;
      if (c + 1 > 0) owed_total++;
   endtask

   task automatic add_text_byte(int ch);
      int r, b, len;
      r = right_edge;
      text_mem[r] = ch[7:0];
      right_edge = r + 1;
      if (!needed[ch]) return;
      if (owed_per_byte[ch] > 0) owed_total--;
      owed_per_byte[ch]--;
      while (owed_total == 0 && left_edge <= r) begin
         while (left_edge < r) begin
            b = text_mem[left_edge];
            if (needed[b] && owed_per_byte[b] >= 0) break;
            if (needed[b]) owed_per_byte[b]++;
            left_edge++;
         end
         len = r - left_edge + 1;
         if (best_length == 0 || len < best_length) begin
            best_length = len;
            best_index = left_edge;
         end
         b = text_mem[left_edge];
         if (needed[b]) begin
            owed_per_byte[b]++;
            if (owed_per_byte[b] > 0) owed_total++;
         end
         left_edge++;
      end
   endtask

   task automatic predict_window(bit op, int ch, bit last);
      window_type w;
      if (op == OP_PATTERN) begin
         add_pattern_byte(ch);
         return;
      end
      if (right_edge < MAX_TEXT) add_text_byte(ch);
      if (!last) return;
      w.found = (best_length != 0);
      w.start_res = best_index[mws_pkg::START_W-1:0];
      w.length = best_length[mws_pkg::LENGTH_W-1:0];
      expected_windows.push_back(w);
      clear_window_job();
   endtask

   function automatic int gap_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
   endfunction

   // Offers one item and waits for its transfer; the model is updated on acceptance.
   // Valid stays high after the transfer so that back-to-back items need no extra edge.
   task automatic send_item(bit op, int ch, bit last);
      int gap;
      gap = req_gaps_on ? gap_length() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_ch <= ch[7:0];
      req_last <= last;
      do @(posedge clock); while (req_stall);
      predict_window(op, ch, last);
      items_sent++;
   endtask

   task automatic send_job(int pattern[$], int text[$]);
      foreach (pattern[i]) send_item(OP_PATTERN, pattern[i], 1'b0);
      foreach (text[i]) send_item(OP_TEXT, text[i], i == text.size() - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_windows.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      int p[$];
      int t[$];
      // Classic case with a shorter window found later.
      p = '{8'h41, 8'h42, 8'h43};
      t = '{8'h41, 8'h44, 8'h4f, 8'h42, 8'h45, 8'h43, 8'h4f, 8'h44, 8'h45, 8'h42,
            8'h41, 8'h4e, 8'h43};
      send_job(p, t);
      // Empty pattern gives no window.
      p = {};
      t = '{8'h00, 8'hff};
      send_job(p, t);
      // Extreme byte values and repeated pattern bytes with ties.
      p = '{8'h00, 8'hff, 8'hff};
      t = '{8'hff, 8'h00, 8'hff, 8'h00, 8'hff};
      send_job(p, t);
      // The last mark on a pattern byte is ignored, then a pattern byte arrives mid-text.
      send_item(OP_PATTERN, 8'h55, 1'b1);
      send_item(OP_TEXT, 8'h55, 1'b0);
      send_item(OP_PATTERN, 8'haa, 1'b0);
      send_item(OP_TEXT, 8'haa, 1'b1);
      wait_drained();
   endtask

   task automatic test_long_text();
      int i;
      // Text beyond the store is ignored but the last mark still ends the job.
      send_item(OP_PATTERN, 8'h07, 1'b0);
      send_item(OP_PATTERN, 8'h09, 1'b0);
      for (i = 0; i < MAX_TEXT + 3; i++)
         send_item(OP_TEXT, (i == 700) ? 8'h07 : (i == 705) ? 8'h09 : $urandom_range(16, 255),
                   i == MAX_TEXT + 2);
      wait_drained();
   endtask

   task automatic test_random_jobs();
      int p[$];
      int t[$];
      int sent_at_start, k, n, alpha;
      sent_at_start = items_sent;
      while (items_sent - sent_at_start < 400) begin
         p = {};
         t = {};
         alpha = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(2, 6);
         n = $urandom_range(0, 4);
         for (k = 0; k < n; k++) p.push_back($urandom_range(0, alpha - 1));
         n = $urandom_range(1, 14);
         for (k = 0; k < n; k++) t.push_back($urandom_range(0, alpha - 1));
         if ($urandom_range(0, 9) == 0)
            send_item(OP_TEXT, $urandom_range(0, 255), 1'b0);
         send_job(p, t);
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      int p[$];
      int t[$];
      int k;
      req_gaps_on = 1'b0;
      hold_results = 1'b1;
      for (k = 0; k < 6; k++) begin
         p = '{k, k + 1};
         t = '{k + 1, 8'h80, k};
         send_job(p, t);
      end
      hold_results = 1'b0;
      req_gaps_on = 1'b1;
      wait_drained();
   endtask

   // Receiver: stalls at random, or for a long counted stretch when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_results) begin
         rsp_stall <= 1'b1;
      end else if (rsp_gaps_on) begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compares each result transfer with the oldest prediction.
   always @(posedge clock) begin
      window_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_windows.size() == 0) begin
            $display("%0t: unexpected result found=%0d start=%0d length=%0d",
                     $time, rsp_found, rsp_start_res, rsp_length);
            error_count++;
         end else begin
            w = expected_windows.pop_front();
            windows_checked++;
            if (rsp_found !== w.found) begin
               $display("%0t: found expected %0d actual %0d", $time, w.found, rsp_found);
               error_count++;
            end
            if (rsp_start_res !== w.start_res) begin
               $display("%0t: start expected %0d actual %0d", $time, w.start_res,
                        rsp_start_res);
               error_count++;
            end
            if (rsp_length !== w.length) begin
               $display("%0t: length expected %0d actual %0d", $time, w.length, rsp_length);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer; the long hold-off stays well within it.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Holds results back for a counted stretch while the sender keeps offering.
   initial begin
      int hold;
      @(negedge reset);
      wait (hold_results);
      for (hold = 0; hold < 400; hold++) @(posedge clock);
      hold_results = 1'b0;
   end

   initial begin
      clear_window_job();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_long_text();
      test_backpressure();
      test_random_jobs();
      rsp_gaps_on = 1'b0;
      wait_drained();
      repeat (50) @(posedge clock);
      $display("Covered %0d request transfers and %0d checked windows, including an",
               items_sent, windows_checked);
      $display("over-long text, mid-text pattern bytes and a long result hold-off.");
      if (error_count == 0 && expected_windows.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
